// File: src/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
package wsd_pkg;

  // Result kinds
  localparam logic [1:0] KindPayload = 2'd0;
  localparam logic [1:0] KindEmpty   = 2'd1;
  localparam logic [1:0] KindError   = 2'd2;

  // Error codes
  localparam logic [2:0] ErrNone      = 3'd0;
  localparam logic [2:0] ErrClose     = 3'd1;
  localparam logic [2:0] ErrNotMasked = 3'd2;
  localparam logic [2:0] ErrLen64     = 3'd3;
  localparam logic [2:0] ErrTooLong   = 3'd4;

  // Header fields
  localparam logic [3:0] OpText  = 4'h1;
  localparam logic [3:0] OpClose = 4'h8;
  localparam logic [6:0] Len7Ext16 = 7'd126;
  localparam logic [6:0] Len7Ext64 = 7'd127;

  localparam logic [15:0] MaxLenReset = 16'd4095;

  // One classified beat handed from the parser to the output side
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [7:0]  key;
    logic        last;
    logic [2:0]  err;
    logic [15:0] len;
  } wsd_item_t;

endpackage

// File: src/websocket_frame_deframer.sv
// Top level of the masked text WebSocket frame deframer.
//
//   channel   direction  handshake          fields
//   input     in         push / full        stream_byte_i
//   result    out        empty / pop        result_kind_o, payload_byte_o, last_byte_o,
//                                           error_code_o, frame_length_o
//   config    in         cfg_we_i           cfg_wdata_i (max payload length)
//
// One byte is taken per cycle while full is low; the parser updates its phase in the
// cycle the byte is accepted. A result passes through the two-entry queue and then
// the output register before it shows on the ports. Reset returns the parser to the
// first header byte and sets the length limit to 4095. When pop stays low the queue
// fills and full rises after two further results; bytes that make no result never
// enter the queue.
module websocket_frame_deframer import wsd_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  stream_byte_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_byte_o,
  output logic [2:0]  error_code_o,
  output logic [15:0] frame_length_o
);

  logic      accept;
  logic      item_valid;
  wsd_item_t item;
  logic      q_empty;
  logic      q_rd;
  wsd_item_t q_item;

  assign accept = push && !full;

  wsd_front #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .stream_byte_i(stream_byte_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  wsd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (item_valid),
    .wr_item_i(item),
    .full_o   (full),
    .rd_en_i  (q_rd),
    .empty_o  (q_empty),
    .rd_item_o(q_item)
  );

  wsd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_item_i      (q_item),
    .q_rd_o        (q_rd),
    .pop_i         (pop),
    .empty_o       (empty),
    .result_kind_o (result_kind_o),
    .payload_byte_o(payload_byte_o),
    .last_byte_o   (last_byte_o),
    .error_code_o  (error_code_o),
    .frame_length_o(frame_length_o)
  );

endmodule

// File: src/wsd_front.sv
// Header parser: classifies each stream byte and tracks frame state.
module wsd_front import wsd_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  stream_byte_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        item_valid_o,
  output wsd_item_t   item_o
);

  localparam logic [2:0] PhHdr0  = 3'd0;
  localparam logic [2:0] PhHdr1  = 3'd1;
  localparam logic [2:0] PhExtHi = 3'd2;
  localparam logic [2:0] PhExtLo = 3'd3;
  localparam logic [2:0] PhMask  = 3'd4;
  localparam logic [2:0] PhData  = 3'd5;

  localparam logic [16:0] BufLimit = 17'(BUFFER_BYTES);

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic [15:0] len_q, len_d;
  logic [15:0] left_q, left_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  midx_q, midx_d;
  logic [15:0] max_len_q;

  // Next-state and classification of the current byte
  always_comb begin
    logic [6:0]  len7;
    logic [15:0] len_cand;
    logic        too_long;
    len7     = stream_byte_i[6:0];
    len_cand = (phase_q == PhExtLo) ? {len_q[15:8], stream_byte_i} : {9'd0, len7};
    too_long = (len_cand > max_len_q) || ({1'b0, len_cand} >= BufLimit);

    phase_d      = phase_q;
    opcode_d     = opcode_q;
    len_d        = len_q;
    left_d       = left_q;
    key_d        = key_q;
    midx_d       = midx_q;
    item_valid_o = 1'b0;
    item_o       = '0;

    if (accept_i) begin
      unique case (phase_q)
        PhHdr1: begin
          if (opcode_q == OpClose) begin
            item_valid_o = 1'b1;
            item_o.kind  = KindError;
            item_o.err   = ErrClose;
            phase_d      = PhHdr0;
          end else if (opcode_q != OpText || !stream_byte_i[7]) begin
            item_valid_o = 1'b1;
            item_o.kind  = KindError;
            item_o.err   = ErrNotMasked;
            phase_d      = PhHdr0;
          end else if (len7 == Len7Ext64) begin
            item_valid_o = 1'b1;
            item_o.kind  = KindError;
            item_o.err   = ErrLen64;
            phase_d      = PhHdr0;
          end else if (len7 == Len7Ext16) begin
            len_d   = '0;
            phase_d = PhExtHi;
          end else begin
            len_d = len_cand;
            if (too_long) begin
              item_valid_o = 1'b1;
              item_o.kind  = KindError;
              item_o.err   = ErrTooLong;
              item_o.len   = len_cand;
              phase_d      = PhHdr0;
            end else begin
              midx_d  = '0;
              phase_d = PhMask;
            end
          end
        end
        PhExtHi: begin
          len_d   = {stream_byte_i, 8'd0};
          phase_d = PhExtLo;
        end
        PhExtLo: begin
          len_d = len_cand;
          if (too_long) begin
            item_valid_o = 1'b1;
            item_o.kind  = KindError;
            item_o.err   = ErrTooLong;
            item_o.len   = len_cand;
            phase_d      = PhHdr0;
          end else begin
            midx_d  = '0;
            phase_d = PhMask;
          end
        end
        PhMask: begin
          key_d  = {key_q[23:0], stream_byte_i};
          midx_d = midx_q + 2'd1;
          if (midx_q == 2'd3) begin
            if (len_q == '0) begin
              item_valid_o = 1'b1;
              item_o.kind  = KindEmpty;
              phase_d      = PhHdr0;
            end else begin
              left_d  = len_q;
              phase_d = PhData;
            end
          end
        end
        PhData: begin
          midx_d       = midx_q + 2'd1;
          left_d       = left_q - 16'd1;
          item_valid_o = 1'b1;
          item_o.kind  = KindPayload;
          item_o.data  = stream_byte_i;
          item_o.last  = (left_q == 16'd1);
          item_o.len   = len_q;
          case (midx_q)
            2'd0:    item_o.key = key_q[31:24];
            2'd1:    item_o.key = key_q[23:16];
            2'd2:    item_o.key = key_q[15:8];
            default: item_o.key = key_q[7:0];
          endcase
          if (left_q == 16'd1) begin
            phase_d = PhHdr0;
          end
        end
        default: begin
          // First header byte, and any unused phase code
          opcode_d = stream_byte_i[3:0];
          phase_d  = PhHdr1;
        end
      endcase
    end
  end

  // Hold frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHdr0;
      opcode_q <= '0;
      len_q    <= '0;
      left_q   <= '0;
      key_q    <= '0;
      midx_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      len_q    <= len_d;
      left_q   <= left_d;
      key_q    <= key_d;
      midx_q   <= midx_d;
    end
  end

  // Hold the length limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

endmodule

// File: src/wsd_queue.sv
// Two-entry queue between the parser and the output side.
module wsd_queue import wsd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_en_i,
  input  wsd_item_t wr_item_i,
  output logic      full_o,
  input  logic      rd_en_i,
  output logic      empty_o,
  output wsd_item_t rd_item_o
);

  wsd_item_t   mem_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  count_q, count_d;
  logic        do_wr, do_rd;

  assign full_o    = (count_q == 2'd2);
  assign empty_o   = (count_q == 2'd0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_item_o = mem_q[rptr_q];

  // Track fill level
  always_comb begin
    count_d = count_q;
    if (do_wr && !do_rd) begin
      count_d = count_q + 2'd1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 2'd1;
    end
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (do_wr) begin
        wptr_q <= ~wptr_q;
      end
      if (do_rd) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_item_i;
    end
  end

endmodule

// File: src/wsd_back.sv
// Output stage: unmasks payload beats into the result register.
module wsd_back import wsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  wsd_item_t   q_item_i,
  output logic        q_rd_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_byte_o,
  output logic [2:0]  error_code_o,
  output logic [15:0] frame_length_o
);

  logic        valid_q;
  logic [1:0]  kind_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic [2:0]  err_q;
  logic [15:0] len_q;

  assign empty_o = !valid_q;
  assign q_rd_o  = !q_empty_i && (!valid_q || pop_i);

  // Track result register occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_rd_o) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  // Load and unmask the next beat
  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      kind_q <= q_item_i.kind;
      byte_q <= q_item_i.data ^ q_item_i.key;
      last_q <= q_item_i.last;
      err_q  <= q_item_i.err;
      len_q  <= q_item_i.len;
    end
  end

  assign result_kind_o  = kind_q;
  assign payload_byte_o = byte_q;
  assign last_byte_o    = last_q;
  assign error_code_o   = err_q;
  assign frame_length_o = len_q;

endmodule

// File: tb/tb_websocket_frame_deframer.sv
// Self-checking testbench for the masked text WebSocket frame deframer.
`timescale 1ns / 100ps

module tb_websocket_frame_deframer;
  import wsd_pkg::*;

  localparam int unsigned BufferBytes = 4096;
  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned PhaseBytes  = 170;
  localparam logic        MaskBit     = 1'b1;
  localparam logic [3:0]  FinFlags    = 4'h8;

  // Parser phases of the predictor
  typedef enum logic [2:0] {
    PhHdr0, PhHdr1, PhExtHi, PhExtLo, PhMask, PhData
  } rx_phase_e;

  // One expected result beat
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        last;
    logic [2:0]  err;
    logic [15:0] len;
  } deframed_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic        full;
  logic [7:0]  stream_byte = '0;
  logic        cfg_we      = 1'b0;
  logic [15:0] cfg_wdata   = '0;
  logic        empty;
  logic        pop         = 1'b0;
  logic [1:0]  result_kind;
  logic [7:0]  payload_byte;
  logic        last_byte;
  logic [2:0]  error_code;
  logic [15:0] frame_length;

  // Predictor state and its copy of the length limit
  rx_phase_e   rx_phase;
  logic [3:0]  op_nibble;
  logic [15:0] pay_len;
  logic [15:0] pay_left;
  logic [31:0] mask_word;
  logic [1:0]  mask_pos;
  logic [15:0] len_limit;

  deframed_t   deframed_q[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned bytes_sent     = 0;
  int unsigned gap_pct        = 0;
  int unsigned stall_pct      = 0;
  int unsigned hold_len       = 0;
  int unsigned hold_id        = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;

  websocket_frame_deframer #(
    .BUFFER_BYTES(BufferBytes)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .stream_byte_i (stream_byte),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .empty         (empty),
    .pop           (pop),
    .result_kind_o (result_kind),
    .payload_byte_o(payload_byte),
    .last_byte_o   (last_byte),
    .error_code_o  (error_code),
    .frame_length_o(frame_length)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_websocket_frame_deframer: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void expect_result(logic [1:0] kind, logic [7:0] data, logic last,
                                        logic [2:0] err, logic [15:0] len);
    deframed_t beat;
    beat.kind = kind;
    beat.data = data;
    beat.last = last;
    beat.err  = err;
    beat.len  = len;
    deframed_q.push_back(beat);
  endfunction

  function automatic void flag_error(logic [2:0] err, logic [15:0] len);
    rx_phase = PhHdr0;
    expect_result(KindError, 8'h00, 1'b0, err, len);
  endfunction

  // Length is complete: reject it or move on to the mask key
  function automatic void check_frame_len();
    if (pay_len > len_limit || pay_len >= BufferBytes) begin
      flag_error(ErrTooLong, pay_len);
    end else begin
      mask_pos = 2'd0;
      rx_phase = PhMask;
    end
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    logic [7:0] key;
    case (rx_phase)
      PhHdr1: begin
        if (op_nibble == OpClose) begin
          flag_error(ErrClose, 16'd0);
        end else if (op_nibble != OpText || !b[7]) begin
          flag_error(ErrNotMasked, 16'd0);
        end else if (b[6:0] == Len7Ext64) begin
          flag_error(ErrLen64, 16'd0);
        end else if (b[6:0] == Len7Ext16) begin
          pay_len  = 16'd0;
          rx_phase = PhExtHi;
        end else begin
          pay_len = {9'd0, b[6:0]};
          check_frame_len();
        end
      end
      PhExtHi: begin
        pay_len  = {b, 8'h00};
        rx_phase = PhExtLo;
      end
      PhExtLo: begin
        pay_len[7:0] = b;
        check_frame_len();
      end
      PhMask: begin
        mask_word = {mask_word[23:0], b};
        mask_pos  = mask_pos + 2'd1;
        if (mask_pos == 2'd0) begin
          if (pay_len == 16'd0) begin
            rx_phase = PhHdr0;
            expect_result(KindEmpty, 8'h00, 1'b0, ErrNone, 16'd0);
          end else begin
            pay_left = pay_len;
            rx_phase = PhData;
          end
        end
      end
      PhData: begin
        key      = mask_word[8 * (3 - int'(mask_pos)) +: 8];
        mask_pos = mask_pos + 2'd1;
        pay_left = pay_left - 16'd1;
        if (pay_left == 16'd0) rx_phase = PhHdr0;
        expect_result(KindPayload, b ^ key, pay_left == 16'd0, ErrNone, pay_len);
      end
      default: begin
        op_nibble = b[3:0];
        rx_phase  = PhHdr1;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatch_count++;
    $display("mismatch on %s: got %h, expected %h (cycle %0d)", what, got, want,
             cycle_count);
  endtask

  always @(posedge clk_i) begin : check_deframed
    deframed_t want;
    if (rst_ni && pop && !empty) begin
      if (deframed_q.size() == 0) begin
        report_mismatch("unexpected result beat", {14'd0, result_kind}, 16'd0);
      end else begin
        want = deframed_q.pop_front();
        if (result_kind !== want.kind)
          report_mismatch("result_kind", {14'd0, result_kind}, {14'd0, want.kind});
        if (payload_byte !== want.data)
          report_mismatch("payload_byte", {8'd0, payload_byte}, {8'd0, want.data});
        if (last_byte !== want.last)
          report_mismatch("last_byte", {15'd0, last_byte}, {15'd0, want.last});
        if (error_code !== want.err)
          report_mismatch("error_code", {13'd0, error_code}, {13'd0, want.err});
        if (frame_length !== want.len)
          report_mismatch("frame_length", frame_length, want.len);
      end
    end
  end

  // Drive pop: random stalls, or a long hold-off when one is requested
  always @(posedge clk_i) begin : drive_pop
    if (hold_id != hold_seen) begin
      hold_seen <= hold_id;
      hold_left <= hold_len;
      pop       <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop       <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one byte, hold it until the block takes it, then predict
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < gap_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    stream_byte <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
    deframe_byte(b);
  endtask

  // Feed random bytes until the parser is back at a frame header
  task automatic finish_frame();
    while (rx_phase != PhHdr0) send_byte(8'($urandom));
  endtask

  task automatic send_frame(input logic [3:0] flags, input logic [3:0] opcode,
                            input logic masked, input logic [6:0] len7,
                            input logic [15:0] ext_len);
    send_byte({flags, opcode});
    send_byte({masked, len7});
    if (rx_phase == PhExtHi) begin
      send_byte(ext_len[15:8]);
      send_byte(ext_len[7:0]);
    end
    finish_frame();
  endtask

  // Let every expected beat arrive, plus the pipeline depth
  task automatic wait_for_drain();
    push <= 1'b0;
    do @(posedge clk_i); while (deframed_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_max_len(input logic [15:0] value);
    wait_for_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    len_limit = value;
  endtask

  task automatic send_random_frame();
    int unsigned pick;
    int unsigned sub;
    logic [6:0]  len7;
    logic [15:0] ext_len;
    pick    = $urandom_range(99);
    sub     = $urandom_range(99);
    len7    = 7'($urandom_range(20));
    ext_len = '0;
    if (pick < 70) begin
      // well-formed masked text frame, mostly short
      if (sub < 10) begin
        len7 = 7'($urandom_range(125, 21));
      end else if (sub < 20) begin
        len7    = Len7Ext16;
        ext_len = (sub < 12) ? 16'($urandom) : 16'($urandom_range(400));
      end
      send_frame(4'($urandom), OpText, MaskBit, len7, ext_len);
    end else if (pick < 85) begin
      // broken header
      case (sub % 4)
        0: send_frame(4'($urandom), OpClose, 1'($urandom), 7'($urandom), 16'($urandom));
        1: send_frame(4'($urandom), 4'($urandom), MaskBit, len7, ext_len);
        2: send_frame(4'($urandom), OpText, 1'b0, 7'($urandom), 16'($urandom));
        default: send_frame(4'($urandom), OpText, MaskBit, Len7Ext64, ext_len);
      endcase
    end else begin
      // raw noise, then resync
      repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
      finish_frame();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_header_errors();
    send_frame(FinFlags, OpClose, MaskBit, 7'd5, 16'd0);
    send_frame(4'h0, OpClose, 1'b0, Len7Ext64, 16'd0);
    send_frame(FinFlags, 4'h2, MaskBit, 7'd5, 16'd0);
    send_frame(FinFlags, 4'h0, MaskBit, 7'd5, 16'd0);
    send_frame(FinFlags, OpText, 1'b0, 7'd5, 16'd0);
    send_frame(FinFlags, OpText, MaskBit, Len7Ext64, 16'd0);
  endtask

  task automatic test_short_frames();
    send_frame(FinFlags, OpText, MaskBit, 7'd0, 16'd0);
    // FIN clear and RSV bits set are ignored
    send_frame(4'h7, OpText, MaskBit, 7'd1, 16'd0);
  endtask

  task automatic test_length_limits();
    set_max_len(16'h0000);
    send_frame(FinFlags, OpText, MaskBit, 7'd1, 16'd0);
    send_frame(FinFlags, OpText, MaskBit, Len7Ext16, 16'd0);
    set_max_len(16'd20);
    send_frame(FinFlags, OpText, MaskBit, 7'd20, 16'd0);
    send_frame(FinFlags, OpText, MaskBit, 7'd21, 16'd0);
    send_frame(FinFlags, OpText, MaskBit, Len7Ext16, 16'd300);
    send_frame(FinFlags, OpText, MaskBit, Len7Ext16, 16'd5);
    set_max_len(16'hFFFF);
    send_frame(FinFlags, OpText, MaskBit, Len7Ext16, 16'(BufferBytes));
    send_frame(FinFlags, OpText, MaskBit, Len7Ext16, 16'hFFFF);
    send_frame(FinFlags, OpText, MaskBit, 7'd125, 16'd0);
  endtask

  // Hold pop low long enough to fill the block and stall its input
  task automatic test_backpressure();
    gap_pct   = 0;
    stall_pct <= 0;
    set_max_len(MaxLenReset);
    hold_len <= 300;
    hold_id  <= hold_id + 1;
    send_frame(FinFlags, OpText, MaskBit, 7'd120, 16'd0);
    wait_for_drain();
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          gap_pct = 0;
          stall_pct <= 0;
          set_max_len(MaxLenReset);
        end
        1: begin
          gap_pct = 57;
          stall_pct <= 0;
          set_max_len(16'($urandom_range(300, 10)));
        end
        2: begin
          gap_pct = 0;
          stall_pct <= 57;
          set_max_len(16'hFFFF);
        end
        default: begin
          gap_pct = 22;
          stall_pct <= 22;
          set_max_len(16'h0000);
        end
      endcase
      start = bytes_sent;
      while (bytes_sent - start < PhaseBytes) send_random_frame();
    end
  endtask

  initial begin
    rx_phase  = PhHdr0;
    op_nibble = '0;
    pay_len   = '0;
    pay_left  = '0;
    mask_word = '0;
    mask_pos  = '0;
    len_limit = MaxLenReset;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_header_errors();
    test_short_frames();
    test_length_limits();
    test_backpressure();
    test_random_traffic();
    wait_for_drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_websocket_frame_deframer: clean");
    end else begin
      $display("tb_websocket_frame_deframer: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
src/wsd_pkg.sv
src/wsd_front.sv
src/wsd_queue.sv
src/wsd_back.sv
src/websocket_frame_deframer.sv
tb/tb_websocket_frame_deframer.sv
